// ----- sv/tbhfd_pkg.sv -----
// Shared constants, register indexes and sizes of the two-byte-header frame deframer.
package tbhfd_pkg;

  localparam int MAX_PAYLOAD = 31;
  localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEADER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE     = 2'd2;

  localparam logic [BYTE_W-1:0] FIRST_HEADER_RST  = 8'd35;  // '#'
  localparam logic [BYTE_W-1:0] SECOND_HEADER_RST = 8'd64;  // '@'
  localparam logic [BYTE_W-1:0] TAIL_BYTE_RST     = 8'd42;  // '*'

endpackage

// ----- sv/tbhfd_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module tbhfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/two_byte_header_frame_deframer_top.sv -----
// Top level of the two-byte-header frame deframer: header hunt, payload store and replay.
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready   in_tdata = rx_byte
//   out_     out  out_tvalid/out_tready out_tdata = payload_byte, out_tlast, out_tuser
//   cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// While hunting or collecting, one byte is taken per cycle whenever the output register
// is free. A tail byte closing a frame of n stored bytes starts a replay of n results
// through the single read port of the payload RAM; input is held off until the last result
// is in the output register. An empty frame gives its one result in the cycle after the tail.
// Reset is synchronous: the header and tail registers return to '#', '@', '*'; the RAM is not cleared.
module two_byte_header_frame_deframer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tbhfd_pkg::BYTE_W-1:0]        in_tdata,    // [7:0] rx_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tbhfd_pkg::BYTE_W-1:0]        out_tdata,   // [7:0] payload_byte
  output logic                                out_tlast,
  output logic                                out_tuser,   // [0] empty_frame
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbhfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tbhfd_pkg::BYTE_W-1:0]        cfg_data
);

  typedef enum logic [1:0] {
    ST_HEAD1,
    ST_HEAD2,
    ST_DATA,
    ST_REPLAY
  } state_t;

  state_t state_r, state_nxt;

  logic [tbhfd_pkg::BYTE_W-1:0] first_hdr_r, second_hdr_r, tail_r;
  logic [tbhfd_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [tbhfd_pkg::CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic                         pend_r, pend_nxt;
  logic                         pend_last_r, pend_last_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [tbhfd_pkg::BYTE_W-1:0] out_data_r, out_data_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_empty_r, out_empty_nxt;

  logic                         out_free;
  logic                         in_fire;
  logic                         ram_we, ram_re;
  logic [tbhfd_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [tbhfd_pkg::BYTE_W-1:0] ram_rdata;

  tbhfd_ram #(
    .WIDTH (tbhfd_pkg::BYTE_W),
    .DEPTH (tbhfd_pkg::MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r != ST_REPLAY) && out_free;
  assign in_fire    = in_tvalid && in_tready;
  assign ram_waddr  = cnt_r[tbhfd_pkg::ADDR_W-1:0];
  assign ram_raddr  = rd_idx_r[tbhfd_pkg::ADDR_W-1:0];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_empty_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    case (state_r)
      ST_HEAD2: begin
        if (in_fire) begin
          if (in_tdata == second_hdr_r) begin
            cnt_nxt   = '0;
            state_nxt = ST_DATA;
          end else if (in_tdata == first_hdr_r) begin
            state_nxt = ST_HEAD2;
          end else begin
            state_nxt = ST_HEAD1;
          end
        end
      end
      ST_DATA: begin
        if (in_fire) begin
          if (in_tdata == tail_r) begin
            if (cnt_r == '0) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_last_nxt  = 1'b1;
              out_empty_nxt = 1'b1;
              state_nxt     = ST_HEAD1;
            end else begin
              rd_idx_nxt = '0;
              pend_nxt   = 1'b0;
              state_nxt  = ST_REPLAY;
            end
          end else if (cnt_r < tbhfd_pkg::CNT_W'(tbhfd_pkg::MAX_PAYLOAD)) begin
            ram_we  = 1'b1;
            cnt_nxt = tbhfd_pkg::CNT_W'(cnt_r + 1'b1);
          end else begin
            // overrun: drop the frame and hunt again
            cnt_nxt   = '0;
            state_nxt = ST_HEAD1;
          end
        end
      end
      ST_REPLAY: begin
        // move the read word into the output register once it is free
        if (pend_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ram_rdata;
          out_last_nxt  = pend_last_r;
          out_empty_nxt = 1'b0;
          pend_nxt      = 1'b0;
          if (pend_last_r) begin
            cnt_nxt   = '0;
            state_nxt = ST_HEAD1;
          end
        end
        if ((rd_idx_r < cnt_r) && (!pend_r || out_free)) begin
          ram_re        = 1'b1;
          rd_idx_nxt    = tbhfd_pkg::CNT_W'(rd_idx_r + 1'b1);
          pend_nxt      = 1'b1;
          pend_last_nxt = (tbhfd_pkg::CNT_W'(rd_idx_r + 1'b1) == cnt_r);
        end
      end
      default: begin
        if (in_fire) begin
          state_nxt = (in_tdata == first_hdr_r) ? ST_HEAD2 : ST_HEAD1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_HEAD1;
      cnt_r        <= '0;
      rd_idx_r     <= '0;
      pend_r       <= 1'b0;
      pend_last_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      first_hdr_r  <= tbhfd_pkg::FIRST_HEADER_RST;
      second_hdr_r <= tbhfd_pkg::SECOND_HEADER_RST;
      tail_r       <= tbhfd_pkg::TAIL_BYTE_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tbhfd_pkg::REG_FIRST_HEADER:  first_hdr_r  <= cfg_data;
          tbhfd_pkg::REG_SECOND_HEADER: second_hdr_r <= cfg_data;
          tbhfd_pkg::REG_TAIL_BYTE:     tail_r       <= cfg_data;
          default: ;
        endcase
      end
    end
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

`ifndef NO_ASSERTIONS
  a_no_input_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_REPLAY |-> !in_tready)
    else $error("input taken during replay");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tbhfd_pkg::CNT_W'(tbhfd_pkg::MAX_PAYLOAD))
    else $error("payload count beyond limit");

  a_pend_only_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == ST_REPLAY)
    else $error("read pending outside replay");

  a_ram_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store written and read in one cycle");

  a_empty_result_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_last_r && out_data_r == '0))
    else $error("malformed empty-frame result");
`endif

endmodule
